// ===== src/fpc_pkg.sv =====
// Shared types, widths and codes for the frustum point containment block.
// Used by the request channel interface, the plane cell and the top level.
package fpc_pkg;

    localparam int COORD_WIDTH = 16;

    // Widths of the exact intermediate results of one plane test.
    localparam int EDGE_WIDTH = COORD_WIDTH + 1;         // corner difference
    localparam int DIFF_WIDTH = COORD_WIDTH + 2;         // point minus corner minus offset
    localparam int PROD_WIDTH = 2 * EDGE_WIDTH;          // edge times edge
    localparam int NORM_WIDTH = PROD_WIDTH + 1;          // normal component
    localparam int TERM_WIDTH = NORM_WIDTH + DIFF_WIDTH; // normal times difference
    localparam int SUM_WIDTH  = TERM_WIDTH + 2;          // dot product

    localparam int NUM_PLANES     = 6;
    localparam int CELL_DEPTH     = 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [2:0] corner_idx_t;
    typedef logic [2:0] plane_t;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    localparam plane_t PLANE_FAR    = 3'd0;
    localparam plane_t PLANE_NEAR   = 3'd1;
    localparam plane_t PLANE_LEFT   = 3'd2;
    localparam plane_t PLANE_RIGHT  = 3'd3;
    localparam plane_t PLANE_TOP    = 3'd4;
    localparam plane_t PLANE_BOTTOM = 3'd5;
    localparam plane_t PLANE_NONE   = 3'd6;

    // One item as it moves along the chain of plane cells.
    typedef struct packed {
        logic        action;
        corner_idx_t corner_index;
        coord_t      pt_x;
        coord_t      pt_y;
        coord_t      pt_z;
        coord_t      off_x;
        coord_t      off_y;
        coord_t      off_z;
        plane_t      failed;
    } beat_t;

    // The three corners that span a plane; c1 is the anchor corner.
    typedef struct packed {
        corner_idx_t c1;
        corner_idx_t c2;
        corner_idx_t c3;
    } trio_t;

    function automatic trio_t plane_trio(input plane_t plane);
        trio_t t;
        case (plane)
            PLANE_FAR:    t = '{c1: 3'd4, c2: 3'd5, c3: 3'd6};
            PLANE_NEAR:   t = '{c1: 3'd0, c2: 3'd2, c3: 3'd1};
            PLANE_LEFT:   t = '{c1: 3'd3, c2: 3'd6, c3: 3'd2};
            PLANE_RIGHT:  t = '{c1: 3'd0, c2: 3'd1, c3: 3'd4};
            PLANE_TOP:    t = '{c1: 3'd0, c2: 3'd4, c3: 3'd3};
            PLANE_BOTTOM: t = '{c1: 3'd2, c2: 3'd5, c3: 3'd1};
            default:      t = '{c1: 3'd0, c2: 3'd0, c3: 3'd0};
        endcase
        return t;
    endfunction

endpackage

// ===== src/fpc_req_if.sv =====
// Request channel of the frustum point containment block: corner loads and point tests.
// Depends on fpc_pkg for the coordinate type.
interface fpc_req_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic [2:0]          corner_index;
    fpc_pkg::coord_t     coord_x;
    fpc_pkg::coord_t     coord_y;
    fpc_pkg::coord_t     coord_z;
    fpc_pkg::coord_t     offset_x;
    fpc_pkg::coord_t     offset_y;
    fpc_pkg::coord_t     offset_z;

    modport source (
        output valid, action, corner_index, coord_x, coord_y, coord_z,
               offset_x, offset_y, offset_z,
        input  ready
    );

    modport sink (
        input  valid, action, corner_index, coord_x, coord_y, coord_z,
               offset_x, offset_y, offset_z,
        output ready
    );
endinterface

// ===== src/fpc_rsp_if.sv =====
// Response channel of the frustum point containment block: one beat per point test.
// Self-contained; carries only narrow unsigned fields.
interface fpc_rsp_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [2:0] failed_plane;

    modport source (
        output valid, inside_res, failed_plane,
        input  ready
    );

    modport sink (
        input  valid, inside_res, failed_plane,
        output ready
    );
endinterface

// ===== src/frustum_point_containment.sv =====
// A test point's result passes through six plane cells of five stages each and then
// the response register before it is valid; loads give no result.
// Throughput: one request beat per cycle, loads and tests alike, set by the fully
// pipelined plane cells; the chain stalls only while a finished test waits to leave.
// Reset: rst_n clears all valid bits, the response valid among them; corners, payloads
// and the response plane code are not reset. Depends on fpc_pkg, fpc_req_if, fpc_rsp_if
// and fpc_plane_cell.
module frustum_point_containment (
    input  logic          clk,
    input  logic          rst_n,
    fpc_req_if.sink       req,
    fpc_rsp_if.source     rsp
);

    localparam int NP = fpc_pkg::NUM_PLANES;

    fpc_pkg::beat_t  head_beat;
    fpc_pkg::beat_t  cell_beat [NP];
    logic            cell_valid [NP];
    logic            advance;
    logic            last_test;
    logic            rsp_valid_reg;
    fpc_pkg::plane_t failed_reg;

    always_comb
    begin
        head_beat.action       = req.action;
        head_beat.corner_index = req.corner_index;
        head_beat.pt_x         = req.coord_x;
        head_beat.pt_y         = req.coord_y;
        head_beat.pt_z         = req.coord_z;
        head_beat.off_x        = req.offset_x;
        head_beat.off_y        = req.offset_y;
        head_beat.off_z        = req.offset_z;
        head_beat.failed       = fpc_pkg::PLANE_NONE;
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            fpc_plane_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .plane_id (3'(g)),
                .up_valid (req.valid),
                .up_beat  (head_beat),
                .dn_valid (cell_valid[g]),
                .dn_beat  (cell_beat[g])
            );
        end
        else
        begin : g_body
            fpc_plane_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .plane_id (3'(g)),
                .up_valid (cell_valid[g-1]),
                .up_beat  (cell_beat[g-1]),
                .dn_valid (cell_valid[g]),
                .dn_beat  (cell_beat[g])
            );
        end
    end

    // Loads drop off the end of the chain, so only a finished test can hold it up.
    assign last_test = cell_valid[NP-1] && cell_beat[NP-1].action == fpc_pkg::ACT_TEST;
    assign advance   = !(rsp_valid_reg && !rsp.ready && last_test);
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && last_test)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_test)
        begin
            failed_reg <= cell_beat[NP-1].failed;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.failed_plane = failed_reg;
    assign rsp.inside_res   = failed_reg == fpc_pkg::PLANE_NONE;

    a_stall_holds_test: assert property (@(posedge clk) disable iff (!rst_n)
        (last_test && !advance) |=> (last_test && $stable(cell_beat[NP-1].failed)))
        else $error("finished test changed while the chain was stalled");

    a_failed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (failed_reg <= fpc_pkg::PLANE_NONE))
        else $error("response carries an undefined plane code");

    a_rsp_from_test: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg ##1 rsp_valid_reg) |-> $past(last_test && advance))
        else $error("response raised without a test leaving the chain");

endmodule

// ===== src/fpc_plane_cell.sv =====
// One plane cell: keeps its own copy of the three corners that span its plane and
// runs a five-stage exact sign test on each beat before handing it on. Uses fpc_pkg.
module fpc_plane_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  fpc_pkg::plane_t plane_id,
    input  logic            up_valid,
    input  fpc_pkg::beat_t  up_beat,
    output logic            dn_valid,
    output fpc_pkg::beat_t  dn_beat
);

    localparam int CW    = fpc_pkg::COORD_WIDTH;
    localparam int UW    = fpc_pkg::EDGE_WIDTH;
    localparam int DW    = fpc_pkg::DIFF_WIDTH;
    localparam int PW    = fpc_pkg::PROD_WIDTH;
    localparam int NW    = fpc_pkg::NORM_WIDTH;
    localparam int QW    = fpc_pkg::TERM_WIDTH;
    localparam int SW    = fpc_pkg::SUM_WIDTH;
    localparam int DEPTH = fpc_pkg::CELL_DEPTH;

    fpc_pkg::trio_t         trio;
    logic signed [CW-1:0]   pt [3];
    logic signed [CW-1:0]   off [3];
    logic signed [CW-1:0]   p_reg [3][3];

    logic signed [UW-1:0]   u_next [3];
    logic signed [UW-1:0]   v_next [3];
    logic signed [DW-1:0]   d_next [3];
    logic signed [UW-1:0]   u_reg [3];
    logic signed [UW-1:0]   v_reg [3];

    logic signed [PW-1:0]   m_next [6];
    logic signed [PW-1:0]   m_reg [6];
    logic signed [NW-1:0]   n_next [3];
    logic signed [NW-1:0]   n_reg [3];
    logic signed [QW-1:0]   q_next [3];
    logic signed [QW-1:0]   q_reg [3];
    logic signed [SW-1:0]   sum_next;

    logic signed [DW-1:0]   d1_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [DW-1:0]   d3_reg [3];

    fpc_pkg::beat_t         b_reg [DEPTH];
    fpc_pkg::beat_t         out_next;
    logic                   vld_reg [DEPTH];
    logic                   load_hit;

    always_comb
    begin
        trio   = fpc_pkg::plane_trio(plane_id);
        pt[0]  = up_beat.pt_x;
        pt[1]  = up_beat.pt_y;
        pt[2]  = up_beat.pt_z;
        off[0] = up_beat.off_x;
        off[1] = up_beat.off_y;
        off[2] = up_beat.off_z;
        for (int a = 0; a < 3; a++)
        begin
            u_next[a] = UW'(p_reg[1][a]) - UW'(p_reg[0][a]);
            v_next[a] = UW'(p_reg[2][a]) - UW'(p_reg[0][a]);
            d_next[a] = DW'(pt[a]) - DW'(off[a]) - DW'(p_reg[0][a]);
        end
    end

    // The translation cancels out of the normal, so only the difference vector sees it.
    always_comb
    begin
        m_next[0] = PW'(u_reg[1]) * PW'(v_reg[2]);
        m_next[1] = PW'(u_reg[2]) * PW'(v_reg[1]);
        m_next[2] = PW'(u_reg[2]) * PW'(v_reg[0]);
        m_next[3] = PW'(u_reg[0]) * PW'(v_reg[2]);
        m_next[4] = PW'(u_reg[0]) * PW'(v_reg[1]);
        m_next[5] = PW'(u_reg[1]) * PW'(v_reg[0]);
        n_next[0] = NW'(m_reg[0]) - NW'(m_reg[1]);
        n_next[1] = NW'(m_reg[2]) - NW'(m_reg[3]);
        n_next[2] = NW'(m_reg[4]) - NW'(m_reg[5]);
        for (int a = 0; a < 3; a++)
        begin
            q_next[a] = QW'(n_reg[a]) * QW'(d3_reg[a]);
        end
        sum_next = SW'(q_reg[0]) + SW'(q_reg[1]) + SW'(q_reg[2]);
    end

    // A test keeps the first failing plane it met; a zero dot product passes.
    always_comb
    begin
        out_next = b_reg[DEPTH-2];
        if (out_next.action == fpc_pkg::ACT_TEST && out_next.failed == fpc_pkg::PLANE_NONE
            && sum_next[SW-1])
        begin
            out_next.failed = plane_id;
        end
    end

    assign load_hit = advance && up_valid && up_beat.action == fpc_pkg::ACT_LOAD;

    // Corners change on the same edge that the load beat enters the cell, so a test
    // behind it sees the new value and a test ahead of it has already taken the old one.
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (up_beat.corner_index == trio.c1)
                begin
                    p_reg[0][a] <= pt[a];
                end
                if (up_beat.corner_index == trio.c2)
                begin
                    p_reg[1][a] <= pt[a];
                end
                if (up_beat.corner_index == trio.c3)
                begin
                    p_reg[2][a] <= pt[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                u_reg[a]  <= u_next[a];
                v_reg[a]  <= v_next[a];
                d1_reg[a] <= d_next[a];
                d2_reg[a] <= d1_reg[a];
                d3_reg[a] <= d2_reg[a];
                n_reg[a]  <= n_next[a];
                q_reg[a]  <= q_next[a];
            end
            for (int k = 0; k < 6; k++)
            begin
                m_reg[k] <= m_next[k];
            end
            b_reg[0] <= up_beat;
            for (int s = 1; s < DEPTH - 1; s++)
            begin
                b_reg[s] <= b_reg[s-1];
            end
            b_reg[DEPTH-1] <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= up_valid;
            for (int s = 1; s < DEPTH; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    assign dn_valid = vld_reg[DEPTH-1];
    assign dn_beat  = b_reg[DEPTH-1];

endmodule
